// ----- rtl/co2_average_level_alarm_top_macros.svh -----
// Assertion macros shared by the alarm checker.
`ifndef CO2_AVERAGE_LEVEL_ALARM_TOP_MACROS_SVH
`define CO2_AVERAGE_LEVEL_ALARM_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CO2ALM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CO2ALM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/co2alm_pkg.sv -----
// Shared types and constants of the gas level alarm.
package co2alm_pkg;

    // Announced level codes.
    typedef enum logic [2:0] {
        GRADE_UNDEF   = 3'd0,
        GRADE_NORMAL  = 3'd1,
        GRADE_MINIMUM = 3'd2,
        GRADE_MEDIUM  = 3'd3,
        GRADE_MAXIMUM = 3'd4,
        GRADE_EXTREME = 3'd5
    } level_t;

    // Input item kinds, carried on s_axis_tuser.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_LEVEL_NORMAL   = 3'd0,
        REG_LEVEL_MINIMUM  = 3'd1,
        REG_LEVEL_MEDIUM   = 3'd2,
        REG_LEVEL_MAXIMUM  = 3'd3,
        REG_LEVEL_EXTREME  = 3'd4,
        REG_REPEAT_MEDIUM  = 3'd5,
        REG_REPEAT_MAXIMUM = 3'd6,
        REG_REPEAT_EXTREME = 3'd7
    } cfg_reg_t;

    localparam int CFG_W    = 16;
    localparam int SAMPLE_W = 16;
    localparam int AVG_W    = 16;
    localparam int NUM_THR  = 5;

    // Register values after reset.
    localparam int RST_LEVEL_NORMAL   = 400;
    localparam int RST_LEVEL_MINIMUM  = 800;
    localparam int RST_LEVEL_MEDIUM   = 1000;
    localparam int RST_LEVEL_MAXIMUM  = 1400;
    localparam int RST_LEVEL_EXTREME  = 2000;
    localparam int RST_REPEAT_MEDIUM  = 600;
    localparam int RST_REPEAT_MAXIMUM = 300;
    localparam int RST_REPEAT_EXTREME = 150;

endpackage

// ----- rtl/co2_average_level_alarm_top.sv -----
// Moving-average gas level alarm: ring, running sum, level classifier, result pipeline.
//
// Each transfer on the slave side is a sensor sample (s_axis_tuser = 0) or one timer
// tick (s_axis_tuser = 1), and each produces exactly one result transfer carrying the
// truncated average of the last WINDOW samples, the level currently announced and an
// announce flag. The block takes one item per clock while s_axis_tready is high; the
// input transfer updates the ring, the running sum and the alarm state and loads the
// first pipeline register, and the output register takes the sum divided by WINDOW
// with a constant reciprocal multiply. Up to two items are in flight ahead of a stalled
// output, and s_axis_tready drops only when both pipeline registers hold data and
// m_axis_tready is low. Thresholds are kept internally pre-scaled by WINDOW so the
// level decision compares the running sum directly. A sample is classified only while
// checking is armed; each check disarms it for CHECK_TICKS ticks. Medium, maximum and
// extreme announcements start a repeat countdown that forgets the announced level when
// it runs out, so the same level is announced again at the next check. Write the
// configuration registers only while no item is in flight.
module co2_average_level_alarm_top #(
    parameter int WINDOW      = 10,
    parameter int CHECK_TICKS = 50
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_ppm
    input  logic [0:0]  s_axis_tuser,   // [0] command
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] average_ppm, [18:16] level, [23:19] zero
    output logic [0:0]  m_axis_tuser,   // [0] announce
    // Configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import co2alm_pkg::*;

    // Ring position width, running sum width, reciprocal divider constants and check counter width.
    localparam int PW     = $clog2(WINDOW);
    localparam int SW     = SAMPLE_W + PW;
    localparam int SHIFT  = SW + PW;
    localparam int RW     = SW + 1;
    localparam int PRW    = SW + RW;
    localparam int RECIP  = ((1 << SHIFT) + WINDOW - 1) / WINDOW;
    localparam int CW     = $clog2(CHECK_TICKS + 1);

    localparam logic [PW-1:0] POS_LAST  = PW'(WINDOW - 1);
    localparam logic [RW-1:0] RECIP_V   = RW'(RECIP);
    localparam logic [CW-1:0] CHECK_V   = CW'(CHECK_TICKS);

    // Configuration: thresholds held as level * WINDOW, repeat counts as written.
    logic [SW-1:0]    thr_reg [NUM_THR];
    logic [CFG_W-1:0] rpt_medium_reg;
    logic [CFG_W-1:0] rpt_maximum_reg;
    logic [CFG_W-1:0] rpt_extreme_reg;
    logic [SW-1:0]    thr_scaled;

    // Sample ring and running sum.
    logic [SAMPLE_W-1:0] ring_mem [WINDOW];
    logic [SAMPLE_W-1:0] old_data_reg;
    logic                old_valid_reg;
    logic [SAMPLE_W-1:0] old_word;
    logic [PW-1:0]       pos_reg, pos_next;
    logic                full_reg, full_next;
    logic                wrap;
    logic [SW-1:0]       sum_reg, sum_next, sum_calc;

    // Alarm state.
    level_t              level_reg, level_next;
    level_t              lvl_class;
    logic                check_en_reg, check_en_next;
    logic [CW-1:0]       check_cnt_reg, check_cnt_next;
    logic [CFG_W-1:0]    rpt_cnt_reg, rpt_cnt_next, rpt_load, rpt_dec;
    logic                rpt_act_reg, rpt_act_next;
    logic                announce;
    logic [NUM_THR-1:0]  ge;

    // Pipeline.
    logic                accept, is_sample;
    logic                p1_valid_reg, p1_ready, advance;
    logic [SW-1:0]       p1_sum_reg;
    logic                p1_announce_reg;
    level_t              p1_level_reg;
    logic                out_valid_reg, out_ready;
    logic [AVG_W-1:0]    out_avg_reg;
    logic                out_announce_reg;
    level_t              out_level_reg;
    logic [PRW-1:0]      prod;

    // Handshake: each register stage takes new data when it is empty or draining.
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign p1_ready      = !p1_valid_reg || out_ready;
    assign advance       = p1_valid_reg && out_ready;
    assign s_axis_tready = p1_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_sample     = (s_axis_tuser[0] == CMD_SAMPLE);

    assign thr_scaled = SW'(cfg_wdata) * SW'(WINDOW);

    // Oldest sample leaves the sum; entries never written read as zero.
    assign old_word = old_valid_reg ? old_data_reg : '0;
    assign sum_calc = sum_reg - SW'(old_word) + SW'(s_axis_tdata);
    assign wrap     = (pos_reg == POS_LAST);

    // Classify the new sum against scaled thresholds, tests in priority order.
    always_comb
    begin
        for (int k = 0; k < NUM_THR; k++)
        begin
            ge[k] = (sum_calc >= thr_reg[k]);
        end
        if (ge[0] && !ge[1])
        begin
            lvl_class = GRADE_NORMAL;
        end
        else if (ge[1] && !ge[2])
        begin
            lvl_class = GRADE_MINIMUM;
        end
        else if (ge[2] && !ge[3])
        begin
            lvl_class = GRADE_MEDIUM;
        end
        else if (ge[3] && !ge[4])
        begin
            lvl_class = GRADE_MAXIMUM;
        end
        else if (ge[4])
        begin
            lvl_class = GRADE_EXTREME;
        end
        else
        begin
            lvl_class = GRADE_UNDEF;
        end
    end

    // Repeat count for the new level; zero counts as one.
    always_comb
    begin
        case (lvl_class)
            GRADE_MEDIUM:  rpt_load = rpt_medium_reg;
            GRADE_MAXIMUM: rpt_load = rpt_maximum_reg;
            default:       rpt_load = rpt_extreme_reg;
        endcase
        if (rpt_load == '0)
        begin
            rpt_load = CFG_W'(1);
        end
    end

    assign rpt_dec = (rpt_cnt_reg != '0) ? rpt_cnt_reg - CFG_W'(1) : rpt_cnt_reg;

    // Per-item state update.
    always_comb
    begin
        sum_next       = sum_reg;
        pos_next       = wrap ? '0 : pos_reg + PW'(1);
        full_next      = full_reg;
        level_next     = level_reg;
        check_en_next  = check_en_reg;
        check_cnt_next = check_cnt_reg;
        rpt_cnt_next   = rpt_cnt_reg;
        rpt_act_next   = rpt_act_reg;
        announce       = 1'b0;
        if (accept && is_sample)
        begin
            sum_next  = sum_calc;
            full_next = full_reg || wrap;
            if (check_en_reg)
            begin
                check_en_next  = 1'b0;
                check_cnt_next = CHECK_V;
                if (lvl_class != GRADE_UNDEF && lvl_class != level_reg)
                begin
                    announce     = 1'b1;
                    level_next   = lvl_class;
                    rpt_act_next = 1'b0;
                    rpt_cnt_next = '0;
                    if (lvl_class >= GRADE_MEDIUM)
                    begin
                        rpt_cnt_next = rpt_load;
                        rpt_act_next = 1'b1;
                    end
                end
            end
        end
        else if (accept)
        begin
            // Tick: advance the repeat countdown, then the check countdown.
            if (rpt_act_reg)
            begin
                rpt_cnt_next = rpt_dec;
                if (rpt_dec == '0)
                begin
                    rpt_act_next = 1'b0;
                    level_next   = GRADE_UNDEF;
                end
            end
            if (check_cnt_reg != '0)
            begin
                check_cnt_next = check_cnt_reg - CW'(1);
                if (check_cnt_reg == CW'(1))
                begin
                    check_en_next = 1'b1;
                end
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg[0]      <= SW'(RST_LEVEL_NORMAL * WINDOW);
            thr_reg[1]      <= SW'(RST_LEVEL_MINIMUM * WINDOW);
            thr_reg[2]      <= SW'(RST_LEVEL_MEDIUM * WINDOW);
            thr_reg[3]      <= SW'(RST_LEVEL_MAXIMUM * WINDOW);
            thr_reg[4]      <= SW'(RST_LEVEL_EXTREME * WINDOW);
            rpt_medium_reg  <= CFG_W'(RST_REPEAT_MEDIUM);
            rpt_maximum_reg <= CFG_W'(RST_REPEAT_MAXIMUM);
            rpt_extreme_reg <= CFG_W'(RST_REPEAT_EXTREME);
            sum_reg         <= '0;
            pos_reg         <= '0;
            full_reg        <= 1'b0;
            old_valid_reg   <= 1'b0;
            level_reg       <= GRADE_UNDEF;
            check_en_reg    <= 1'b1;
            check_cnt_reg   <= '0;
            rpt_cnt_reg     <= '0;
            rpt_act_reg     <= 1'b0;
            p1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_LEVEL_NORMAL:   thr_reg[0]      <= thr_scaled;
                    REG_LEVEL_MINIMUM:  thr_reg[1]      <= thr_scaled;
                    REG_LEVEL_MEDIUM:   thr_reg[2]      <= thr_scaled;
                    REG_LEVEL_MAXIMUM:  thr_reg[3]      <= thr_scaled;
                    REG_LEVEL_EXTREME:  thr_reg[4]      <= thr_scaled;
                    REG_REPEAT_MEDIUM:  rpt_medium_reg  <= cfg_wdata;
                    REG_REPEAT_MAXIMUM: rpt_maximum_reg <= cfg_wdata;
                    REG_REPEAT_EXTREME: rpt_extreme_reg <= cfg_wdata;
                    default:            ;
                endcase
            end
            sum_reg       <= sum_next;
            full_reg      <= full_next;
            level_reg     <= level_next;
            check_en_reg  <= check_en_next;
            check_cnt_reg <= check_cnt_next;
            rpt_cnt_reg   <= rpt_cnt_next;
            rpt_act_reg   <= rpt_act_next;
            if (accept && is_sample)
            begin
                pos_reg       <= pos_next;
                old_valid_reg <= full_next;
            end
            if (accept)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (out_ready)
            begin
                out_valid_reg <= p1_valid_reg;
            end
        end
    end

    // Ring write at the current slot; prefetch the next slot's old sample.
    always_ff @(posedge clk)
    begin
        if (accept && is_sample)
        begin
            ring_mem[pos_reg] <= s_axis_tdata;
            old_data_reg      <= ring_mem[pos_next];
        end
    end

    // Average by reciprocal multiply, exact for every sum the ring can hold.
    assign prod = PRW'(p1_sum_reg) * PRW'(RECIP_V);

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_sum_reg      <= sum_next;
            p1_announce_reg <= announce;
            p1_level_reg    <= level_next;
        end
        if (advance)
        begin
            out_avg_reg      <= prod[SHIFT +: AVG_W];
            out_announce_reg <= p1_announce_reg;
            out_level_reg    <= p1_level_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_level_reg, out_avg_reg};
    assign m_axis_tuser  = out_announce_reg;

endmodule

// ----- rtl/co2alm_checker.sv -----
// Port-level checker for the gas level alarm, bound to the top level.
`include "co2_average_level_alarm_top_macros.svh"

module co2alm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);
    import co2alm_pkg::*;

    logic [2:0]  out_level;
    logic        announce_out;
    logic        level_known;
    logic        in_xfer;
    logic        out_stall;
    logic [25:0] out_word;

    assign out_level    = m_axis_tdata[18:16];
    assign announce_out = m_axis_tvalid && m_axis_tuser[0];
    assign level_known  = (out_level != GRADE_UNDEF);
    assign in_xfer      = s_axis_tvalid && s_axis_tready;
    assign out_stall    = m_axis_tvalid && !m_axis_tready;
    assign out_word     = {m_axis_tvalid, m_axis_tuser, m_axis_tdata};

    // An announcement always names a real level.
    `CO2ALM_ASSERT_IMPL(a_announce_level, announce_out, level_known, "announce without level")

    // A new result comes from an input transfer via the p1 register.
    `CO2ALM_ASSERT_IMPL(a_result_src, $rose(m_axis_tvalid), $past(in_xfer, 2), "orphan result")

    // Input back-pressure only when the output is stalled.
    `CO2ALM_ASSERT_IMPL(a_ready_stall, !s_axis_tready, out_stall, "input stall, output free")

    // Hold a stalled result.
    `CO2ALM_ASSERT_NEXT(a_out_hold, out_stall, $stable(out_word), "stalled result changed")

endmodule

bind co2_average_level_alarm_top co2alm_checker u_co2alm_checker (.*);

// ----- test/tb_top.sv -----
// Self-checking testbench for the moving-average gas level alarm.
module tb_top;
    import co2alm_pkg::*;

    localparam int WIN          = 10;
    localparam int CHECK_TICKS  = 50;
    localparam int NUM_REGS     = int'(REG_REPEAT_EXTREME) + 1;
    localparam int STALL_LIMIT  = 3000;   // cycles without any transfer before giving up
    localparam int HOLD_CYCLES  = 60;     // long receiver hold-off that backs up the pipeline

    // One result item as the block reports it.
    typedef struct packed {
        logic [15:0] avg;
        logic        announce;
        level_t      level;
    } alarm_report_t;

    // Tracks the alarm state alongside the block and queues the reports it must produce.
    class alarm_tracker;
        logic [15:0]   regs [NUM_REGS];
        logic [15:0]   ring [WIN];
        logic [19:0]   sum;
        int unsigned   wpos;
        level_t        announced;
        bit            armed;
        logic [15:0]   check_cnt;
        logic [15:0]   repeat_cnt;
        bit            repeat_on;
        alarm_report_t pending_reports [$];
        int            errors;

        function new();
            regs[REG_LEVEL_NORMAL]   = 16'(RST_LEVEL_NORMAL);
            regs[REG_LEVEL_MINIMUM]  = 16'(RST_LEVEL_MINIMUM);
            regs[REG_LEVEL_MEDIUM]   = 16'(RST_LEVEL_MEDIUM);
            regs[REG_LEVEL_MAXIMUM]  = 16'(RST_LEVEL_MAXIMUM);
            regs[REG_LEVEL_EXTREME]  = 16'(RST_LEVEL_EXTREME);
            regs[REG_REPEAT_MEDIUM]  = 16'(RST_REPEAT_MEDIUM);
            regs[REG_REPEAT_MAXIMUM] = 16'(RST_REPEAT_MAXIMUM);
            regs[REG_REPEAT_EXTREME] = 16'(RST_REPEAT_EXTREME);
            foreach (ring[i]) ring[i] = '0;
            sum        = '0;
            wpos       = 0;
            announced  = GRADE_UNDEF;
            armed      = 1'b1;
            check_cnt  = '0;
            repeat_cnt = '0;
            repeat_on  = 1'b0;
            errors     = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [15:0] value);
            regs[idx] = value;
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        // Tests run in fixed order, so unordered thresholds still give one answer.
        function level_t grade_level(logic [15:0] avg);
            if (avg >= regs[REG_LEVEL_NORMAL] && avg < regs[REG_LEVEL_MINIMUM])
                return GRADE_NORMAL;
            if (avg >= regs[REG_LEVEL_MINIMUM] && avg < regs[REG_LEVEL_MEDIUM])
                return GRADE_MINIMUM;
            if (avg >= regs[REG_LEVEL_MEDIUM] && avg < regs[REG_LEVEL_MAXIMUM])
                return GRADE_MEDIUM;
            if (avg >= regs[REG_LEVEL_MAXIMUM] && avg < regs[REG_LEVEL_EXTREME])
                return GRADE_MAXIMUM;
            if (avg >= regs[REG_LEVEL_EXTREME])
                return GRADE_EXTREME;
            return GRADE_UNDEF;
        endfunction

        function void note_item(logic cmd, logic [15:0] ppm);
            alarm_report_t rep;
            level_t        lvl;
            logic [15:0]   reload;
            rep.announce = 1'b0;
            if (cmd == CMD_SAMPLE)
            begin
                sum       = sum - 20'(ring[wpos]) + 20'(ppm);
                ring[wpos] = ppm;
                wpos      = (wpos + 1) % WIN;
                rep.avg   = 16'(sum / WIN);
                if (armed)
                begin
                    armed = 1'b0;
                    lvl   = grade_level(rep.avg);
                    if (lvl != GRADE_UNDEF && lvl != announced)
                    begin
                        rep.announce = 1'b1;
                        announced    = lvl;
                        repeat_on    = 1'b0;
                        repeat_cnt   = '0;
                        reload       = '0;
                        case (lvl)
                            GRADE_MEDIUM:  reload = regs[REG_REPEAT_MEDIUM];
                            GRADE_MAXIMUM: reload = regs[REG_REPEAT_MAXIMUM];
                            GRADE_EXTREME: reload = regs[REG_REPEAT_EXTREME];
                            default:       reload = '0;
                        endcase
                        if (lvl == GRADE_MEDIUM || lvl == GRADE_MAXIMUM || lvl == GRADE_EXTREME)
                        begin
                            // a zero reload expires on the very next tick
                            repeat_cnt = (reload == '0) ? 16'd1 : reload;
                            repeat_on  = 1'b1;
                        end
                    end
                    check_cnt = 16'(CHECK_TICKS);
                end
            end
            else
            begin
                if (repeat_on)
                begin
                    if (repeat_cnt != '0) repeat_cnt = repeat_cnt - 16'd1;
                    if (repeat_cnt == '0)
                    begin
                        repeat_on = 1'b0;
                        announced = GRADE_UNDEF;
                    end
                end
                if (check_cnt != '0)
                begin
                    check_cnt = check_cnt - 16'd1;
                    if (check_cnt == '0) armed = 1'b1;
                end
                rep.avg = 16'(sum / WIN);
            end
            rep.level = announced;
            pending_reports.push_back(rep);
        endfunction

        function void check_report(logic [23:0] data, logic [0:0] user);
            alarm_report_t want;
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected result: average %0d level %0d announce %0d",
                         $time, data[15:0], data[18:16], user[0]);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            if (data[15:0] !== want.avg)
            begin
                $display("%0t: average_ppm mismatch: expected %0d, actual %0d",
                         $time, want.avg, data[15:0]);
                errors++;
            end
            if (data[18:16] !== want.level)
            begin
                $display("%0t: level mismatch: expected %0d, actual %0d",
                         $time, want.level, data[18:16]);
                errors++;
            end
            if (user[0] !== want.announce)
            begin
                $display("%0t: announce mismatch: expected %0d, actual %0d",
                         $time, want.announce, user[0]);
                errors++;
            end
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // [15:0] sample_ppm
    logic [0:0]  s_axis_tuser  = '0;    // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [15:0] average_ppm, [18:16] level, [23:19] zero
    logic [0:0]  m_axis_tuser;          // [0] announce
    logic        cfg_we        = 1'b0;
    logic [2:0]  cfg_index     = '0;
    logic [15:0] cfg_wdata     = '0;

    alarm_tracker tracker = new();

    // Sender burst bookkeeping and the hand-off to the receiver for the long hold-off.
    int burst_left = 0;
    bit no_gaps    = 1'b0;
    bit hold_req   = 1'b0;

    co2_average_level_alarm_top #(
        .WINDOW      (WIN),
        .CHECK_TICKS (CHECK_TICKS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Receiver: alternate ready runs and short stalls, with an occasional long ready
    // stretch; when asked, hold off for HOLD_CYCLES so the block backs up its input.
    initial
    begin
        int  rx_left;
        bit  rx_on;
        int  held;
        rx_left = 0;
        rx_on   = 1'b0;
        held    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                held++;
                if (held >= HOLD_CYCLES)
                begin
                    held     = 0;
                    hold_req = 1'b0;
                end
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_on = !rx_on;
                    if (rx_on)
                        rx_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 25);
                    else
                        rx_left = $urandom_range(1, 6);
                end
                rx_left--;
                m_axis_tready <= rx_on;
            end
        end
    end

    // Check each result transfer and watch for a hung handshake.
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                tracker.check_report(m_axis_tdata, m_axis_tuser);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
            if (idle >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, idle);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Offer one item and hold it until the transfer. Enter and leave at a falling edge;
    // open a random gap first whenever the current burst is used up and gaps are not switched off.
    task automatic send_item(input logic cmd, input logic [15:0] ppm);
        int gap;
        if (!no_gaps && burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ppm;
        s_axis_tuser  <= cmd;
        do @(posedge clk); while (!s_axis_tready);
        tracker.note_item(cmd, ppm);
        @(negedge clk);
        if (burst_left != 0) burst_left--;
    endtask

    // Drop valid and wait until every result is back, then let the pipeline settle.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (tracker.pending() != 0);
        repeat (4) @(negedge clk);
    endtask

    // Write all registers back to back; call only while the block is drained.
    task automatic configure(input logic [15:0] nrm, input logic [15:0] mnm,
                             input logic [15:0] med, input logic [15:0] mxm,
                             input logic [15:0] ext, input logic [15:0] rep_med,
                             input logic [15:0] rep_max, input logic [15:0] rep_ext);
        logic [15:0] vals [NUM_REGS];
        vals[REG_LEVEL_NORMAL]   = nrm;
        vals[REG_LEVEL_MINIMUM]  = mnm;
        vals[REG_LEVEL_MEDIUM]   = med;
        vals[REG_LEVEL_MAXIMUM]  = mxm;
        vals[REG_LEVEL_EXTREME]  = ext;
        vals[REG_REPEAT_MEDIUM]  = rep_med;
        vals[REG_REPEAT_MAXIMUM] = rep_max;
        vals[REG_REPEAT_EXTREME] = rep_ext;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_wdata <= vals[i];
            @(posedge clk);
            tracker.set_reg(cfg_reg_t'(i), vals[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Well-formed alarm cycles: enough ticks to re-arm the check, with samples steering
    // the average toward a target (mostly a threshold edge), then one checking sample.
    task automatic run_checks(input int count);
        logic [15:0] target;
        int          ticks;
        int          pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 5)
                target = tracker.regs[$urandom_range(0, 4)]
                         + 16'($urandom_range(0, 2)) - 16'd1;
            else if (pick == 6)
                target = 16'h0000;
            else if (pick == 7)
                target = 16'hFFFF;
            else
                target = 16'($urandom());
            ticks = 0;
            while (ticks < CHECK_TICKS)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    if ($urandom_range(0, 9) < 7)
                        send_item(CMD_SAMPLE, target);
                    else
                        send_item(CMD_SAMPLE, 16'($urandom()));
                end
                else
                begin
                    // tick payload is ignored; randomize it anyway
                    send_item(CMD_TICK, 16'($urandom()));
                    ticks++;
                end
            end
            send_item(CMD_SAMPLE, target);
        end
    endtask

    // Hold the receiver off and keep offering back to back so the input stalls.
    task automatic squeeze();
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        repeat (24)
        begin
            if ($urandom_range(0, 1) == 0)
                send_item(CMD_SAMPLE, 16'($urandom()));
            else
                send_item(CMD_TICK, 16'($urandom()));
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: full-scale sample straight into an extreme announcement, all-zero
        // and all-one payloads on both kinds, alternating bit patterns, ring wrap.
        send_item(CMD_SAMPLE, 16'hFFFF);
        send_item(CMD_TICK,   16'h0000);
        send_item(CMD_TICK,   16'hFFFF);
        send_item(CMD_SAMPLE, 16'h0000);
        send_item(CMD_SAMPLE, 16'h5555);
        send_item(CMD_SAMPLE, 16'hAAAA);
        send_item(CMD_SAMPLE, 16'hFFFF);
        send_item(CMD_SAMPLE, 16'hFFFF);
        send_item(CMD_SAMPLE, 16'hFFFF);
        send_item(CMD_SAMPLE, 16'hFFFF);
        send_item(CMD_SAMPLE, 16'hFFFF);
        send_item(CMD_SAMPLE, 16'hFFFF);
        send_item(CMD_SAMPLE, 16'hFFFF);
        send_item(CMD_SAMPLE, 16'hFFFF);
        send_item(CMD_SAMPLE, 16'h0001);
        send_item(CMD_TICK,   16'h1234);
        send_item(CMD_SAMPLE, 16'h0000);
        send_item(CMD_SAMPLE, 16'h8000);
        send_item(CMD_TICK,   16'h8000);
        wait_drained();

        // Reset thresholds.
        run_checks(1);
        wait_drained();

        // Tight ascending bands; zero and one repeat reloads expire almost at once.
        configure(16'd100, 16'd200, 16'd300, 16'd400, 16'd500, 16'd0, 16'd1, 16'd2);
        run_checks(1);
        squeeze();
        run_checks(1);
        wait_drained();

        // All thresholds zero: every check lands on extreme; longest repeat.
        configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_checks(1);
        wait_drained();

        // All thresholds at full scale: only a saturated average grades at all.
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd1);
        run_checks(1);
        wait_drained();

        // Unordered random thresholds and short random repeats.
        configure(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                  16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                  16'($urandom_range(0, 3000)), 16'($urandom_range(0, 60)),
                  16'($urandom_range(0, 60)), 16'($urandom_range(0, 60)));
        run_checks(2);
        wait_drained();

        // Reset thresholds again with repeats that run out inside one check period.
        configure(16'(RST_LEVEL_NORMAL), 16'(RST_LEVEL_MINIMUM), 16'(RST_LEVEL_MEDIUM),
                  16'(RST_LEVEL_MAXIMUM), 16'(RST_LEVEL_EXTREME), 16'd5, 16'd7, 16'd3);
        run_checks(1);
        wait_drained();
        repeat (8) @(negedge clk);

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
